### rtl/qrs_pkg.sv
// qrs_pkg: shared constants and case codes for the quadratic root solver
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package qrs_pkg;

  // default coefficient width and fraction bits of the roots
  localparam int COEF_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // width of a root on the result ports
  localparam int ROOT_W = 48;

  // width of the case code
  localparam int CASE_W = 3;

  typedef enum logic [CASE_W-1:0] {
    CASE_ANY     = 3'd0,
    CASE_NONE    = 3'd1,
    CASE_LINEAR  = 3'd2,
    CASE_TWO     = 3'd3,
    CASE_NO_REAL = 3'd4
  } case_t;

endpackage

### rtl/quadratic_root_solver.sv
// the path from the accepting edge to the out_valid beat runs through the front end registers,
// one square root cell per root bit, the numerator register, one divider cell per quotient
// bit and the output register; throughput one beat per cycle, busy is always low
// reset (rst_n, synchronous) clears only the valid bits along the pipeline
// results cannot be stalled: each out_valid beat lasts exactly one cycle
// depends on qrs_pkg, qrs_front, qrs_sqrt_cell, qrs_div_cell
`timescale 1ns / 1ps

module quadratic_root_solver #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [COEF_WIDTH-1:0]   in_coef_square,
  input  logic signed [COEF_WIDTH-1:0]   in_coef_linear,
  input  logic signed [COEF_WIDTH-1:0]   in_coef_const,
  output logic                           out_valid,
  output logic [qrs_pkg::CASE_W-1:0]     out_case_code,
  output logic signed [qrs_pkg::ROOT_W-1:0] out_root_low,
  output logic signed [qrs_pkg::ROOT_W-1:0] out_root_high
);
  import qrs_pkg::*;

  localparam int CW    = COEF_WIDTH;
  localparam int NS    = CW + FRAC_BITS + 1;
  localparam int RADW  = 2*NS;
  localparam int NW    = CW + FRAC_BITS + 2;
  localparam int DNW   = CW + 1;
  localparam int SSW   = CASE_W + 3*CW;
  localparam int DSW   = CASE_W + 2;
  localparam int XW    = ((NW > ROOT_W) ? NW : ROOT_W) + 1;

  assign busy = 1'b0;

  // discriminant front end
  logic                 f_vld;
  case_t                f_case;
  logic signed [CW-1:0] f_a, f_b, f_c;
  logic [RADW-1:0]      f_rad;

  qrs_front #(.COEF_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start && !busy),
    .in_a     (in_coef_square),
    .in_b     (in_coef_linear),
    .in_c     (in_coef_const),
    .out_vld  (f_vld),
    .out_case (f_case),
    .out_a    (f_a),
    .out_b    (f_b),
    .out_c    (f_c),
    .out_rad  (f_rad)
  );

  // square root chain
  logic            sq_vld  [NS+1];
  logic [RADW-1:0] sq_rad  [NS+1];
  logic [NS+1:0]   sq_rem  [NS+1];
  logic [NS-1:0]   sq_root [NS+1];
  logic [SSW-1:0]  sq_side [NS+1];

  assign sq_vld[0]  = f_vld;
  assign sq_rad[0]  = f_rad;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = {f_case, f_a, f_b, f_c};

  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    qrs_sqrt_cell #(.NS(NS), .SIDE_W(SSW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (sq_vld[i]),
      .in_rad   (sq_rad[i]),
      .in_rem   (sq_rem[i]),
      .in_root  (sq_root[i]),
      .in_side  (sq_side[i]),
      .out_vld  (sq_vld[i+1]),
      .out_rad  (sq_rad[i+1]),
      .out_rem  (sq_rem[i+1]),
      .out_root (sq_root[i+1]),
      .out_side (sq_side[i+1])
    );
  end

  // numerators, divisor and quotient signs
  logic [CASE_W-1:0]    q_case;
  logic signed [CW-1:0] q_a, q_b, q_c;
  logic signed [NW:0]   nb, sx, n_lo, n_hi;
  logic signed [CW:0]   den_s;
  logic [DNW-1:0]       den_m;
  logic [NW-1:0]        m_lo, m_hi;
  logic                 sg_lo, sg_hi;

  always_comb begin
    {q_case, q_a, q_b, q_c} = sq_side[NS];
    sx = (NW+1)'(sq_root[NS]);
    if (q_case == CASE_LINEAR) begin
      nb    = -((NW+1)'(q_c) <<< FRAC_BITS);
      n_lo  = nb;
      n_hi  = '0;
      den_s = (CW+1)'(q_b);
    end else begin
      nb    = -((NW+1)'(q_b) <<< FRAC_BITS);
      n_lo  = nb - sx;
      n_hi  = nb + sx;
      den_s = (CW+1)'(q_a) <<< 1;
    end
    den_m = den_s[CW] ? DNW'(-den_s) : DNW'(den_s);
    m_lo  = n_lo[NW] ? NW'(-n_lo) : NW'(n_lo);
    m_hi  = n_hi[NW] ? NW'(-n_hi) : NW'(n_hi);
    sg_lo = n_lo[NW] ^ den_s[CW];
    sg_hi = n_hi[NW] ^ den_s[CW];
  end

  logic           nm_vld_r;
  logic [DNW-1:0] nm_den_r;
  logic [NW-1:0]  nm_lo_r, nm_hi_r;
  logic [DSW-1:0] nm_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm_vld_r <= 1'b0;
    end else begin
      nm_vld_r <= sq_vld[NS];
    end
    nm_den_r  <= den_m;
    nm_lo_r   <= m_lo;
    nm_hi_r   <= m_hi;
    nm_side_r <= {q_case, sg_lo, sg_hi};
  end

  // divider chain
  logic           dv_vld [NW+1];
  logic [DNW-1:0] dv_den [NW+1];
  logic [NW-1:0]  dv_lo  [NW+1];
  logic [NW-1:0]  dv_hi  [NW+1];
  logic [DNW:0]   dv_rlo [NW+1];
  logic [DNW:0]   dv_rhi [NW+1];
  logic [DSW-1:0] dv_side[NW+1];

  assign dv_vld[0]  = nm_vld_r;
  assign dv_den[0]  = nm_den_r;
  assign dv_lo[0]   = nm_lo_r;
  assign dv_hi[0]   = nm_hi_r;
  assign dv_rlo[0]  = '0;
  assign dv_rhi[0]  = '0;
  assign dv_side[0] = nm_side_r;

  for (genvar j = 0; j < NW; j++) begin : g_div
    qrs_div_cell #(.NW(NW), .DNW(DNW), .SIDE_W(DSW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .in_vld     (dv_vld[j]),
      .in_den     (dv_den[j]),
      .in_nq_lo   (dv_lo[j]),
      .in_nq_hi   (dv_hi[j]),
      .in_rem_lo  (dv_rlo[j]),
      .in_rem_hi  (dv_rhi[j]),
      .in_side    (dv_side[j]),
      .out_vld    (dv_vld[j+1]),
      .out_den    (dv_den[j+1]),
      .out_nq_lo  (dv_lo[j+1]),
      .out_nq_hi  (dv_hi[j+1]),
      .out_rem_lo (dv_rlo[j+1]),
      .out_rem_hi (dv_rhi[j+1]),
      .out_side   (dv_side[j+1])
    );
  end

  // sign, saturation and masking of unused roots
  logic [CASE_W-1:0]  o_case;
  logic               o_sg_lo, o_sg_hi;
  logic [XW-1:0]      lim_pos, lim_neg;
  logic [ROOT_W-1:0]  r_lo_nxt, r_hi_nxt;

  function automatic logic [ROOT_W-1:0] fix_root(input logic [XW-1:0] qx, input logic neg,
                                                 input logic [XW-1:0] lp,
                                                 input logic [XW-1:0] ln);
    logic [XW-1:0] nx;
    nx = -qx;
    if (neg) begin
      fix_root = (qx > ln) ? {1'b1, {(ROOT_W-1){1'b0}}} : nx[ROOT_W-1:0];
    end else begin
      fix_root = (qx > lp) ? {1'b0, {(ROOT_W-1){1'b1}}} : qx[ROOT_W-1:0];
    end
  endfunction

  always_comb begin
    {o_case, o_sg_lo, o_sg_hi} = dv_side[NW];
    lim_neg  = XW'(1) << (ROOT_W-1);
    lim_pos  = lim_neg - XW'(1);
    r_lo_nxt = '0;
    r_hi_nxt = '0;
    if (o_case == CASE_LINEAR || o_case == CASE_TWO) begin
      r_lo_nxt = fix_root(XW'(dv_lo[NW]), o_sg_lo, lim_pos, lim_neg);
    end
    if (o_case == CASE_TWO) begin
      r_hi_nxt = fix_root(XW'(dv_hi[NW]), o_sg_hi, lim_pos, lim_neg);
    end
  end

  logic              out_vld_r;
  logic [CASE_W-1:0] out_case_r;
  logic [ROOT_W-1:0] out_lo_r, out_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= dv_vld[NW];
    end
    out_case_r <= o_case;
    out_lo_r   <= r_lo_nxt;
    out_hi_r   <= r_hi_nxt;
  end

  assign out_valid     = out_vld_r;
  assign out_case_code = out_case_r;
  assign out_root_low  = out_lo_r;
  assign out_root_high = out_hi_r;

endmodule

### rtl/qrs_front.sv
// qrs_front: input register, coefficient products and discriminant
// depends on qrs_pkg
`timescale 1ns / 1ps

module qrs_front #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  logic signed [COEF_WIDTH-1:0]   in_a,
  input  logic signed [COEF_WIDTH-1:0]   in_b,
  input  logic signed [COEF_WIDTH-1:0]   in_c,
  output logic                           out_vld,
  output qrs_pkg::case_t                 out_case,
  output logic signed [COEF_WIDTH-1:0]   out_a,
  output logic signed [COEF_WIDTH-1:0]   out_b,
  output logic signed [COEF_WIDTH-1:0]   out_c,
  output logic [2*(COEF_WIDTH+FRAC_BITS+1)-1:0] out_rad
);
  import qrs_pkg::*;

  localparam int CW   = COEF_WIDTH;
  localparam int DW   = 2*CW + 1;
  localparam int RADW = 2*(CW + FRAC_BITS + 1);

  // stage 1: registered coefficients
  logic                 s1_vld_r;
  logic signed [CW-1:0] s1_a_r, s1_b_r, s1_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
    s1_a_r <= in_a;
    s1_b_r <= in_b;
    s1_c_r <= in_c;
  end

  // stage 2: squared b and |a|*|c|
  logic [CW-1:0]        am, bm, cm;
  logic [2*CW-1:0]      b2_nxt, p_nxt;
  logic                 s2_vld_r;
  logic [2*CW-1:0]      s2_b2_r, s2_p_r;
  logic                 s2_neg_r;
  logic signed [CW-1:0] s2_a_r, s2_b_r, s2_c_r;

  always_comb begin
    am     = s1_a_r[CW-1] ? CW'(-s1_a_r) : CW'(s1_a_r);
    bm     = s1_b_r[CW-1] ? CW'(-s1_b_r) : CW'(s1_b_r);
    cm     = s1_c_r[CW-1] ? CW'(-s1_c_r) : CW'(s1_c_r);
    b2_nxt = bm * bm;
    p_nxt  = am * cm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_b2_r  <= b2_nxt;
    s2_p_r   <= p_nxt;
    s2_neg_r <= (s1_a_r[CW-1] != s1_c_r[CW-1]) && (s1_c_r != '0);
    s2_a_r   <= s1_a_r;
    s2_b_r   <= s1_b_r;
    s2_c_r   <= s1_c_r;
  end

  // stage 3: discriminant, case code and scaled radicand
  logic [2*CW+1:0] q4, b2x, dsum, ddif;
  logic [DW-1:0]   d_val;
  case_t           case_nxt;

  always_comb begin
    q4   = {s2_p_r, 2'b00};
    b2x  = (2*CW+2)'(s2_b2_r);
    dsum = b2x + q4;
    ddif = b2x - q4;
    d_val = '0;
    if (s2_a_r == '0) begin
      if (s2_b_r == '0) begin
        case_nxt = (s2_c_r == '0) ? CASE_ANY : CASE_NONE;
      end else begin
        case_nxt = CASE_LINEAR;
      end
    end else if (s2_neg_r) begin
      case_nxt = CASE_TWO;
      d_val    = dsum[DW-1:0];
    end else if (q4 > b2x) begin
      case_nxt = CASE_NO_REAL;
    end else begin
      case_nxt = CASE_TWO;
      d_val    = ddif[DW-1:0];
    end
  end

  logic            s3_vld_r;
  case_t           s3_case_r;
  logic signed [CW-1:0] s3_a_r, s3_b_r, s3_c_r;
  logic [RADW-1:0] s3_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_case_r <= case_nxt;
    s3_a_r    <= s2_a_r;
    s3_b_r    <= s2_b_r;
    s3_c_r    <= s2_c_r;
    s3_rad_r  <= RADW'(d_val) << (2*FRAC_BITS);
  end

  assign out_vld  = s3_vld_r;
  assign out_case = s3_case_r;
  assign out_a    = s3_a_r;
  assign out_b    = s3_b_r;
  assign out_c    = s3_c_r;
  assign out_rad  = s3_rad_r;

endmodule

### rtl/qrs_sqrt_cell.sv
// qrs_sqrt_cell: one root bit of the square root chain, two radicand bits per cell
// depends on qrs_pkg
`timescale 1ns / 1ps

module qrs_sqrt_cell #(
  parameter int NS     = qrs_pkg::COEF_WIDTH_DEF + qrs_pkg::FRAC_BITS_DEF + 1,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [2*NS-1:0]   in_rad,
  input  logic [NS+1:0]     in_rem,
  input  logic [NS-1:0]     in_root,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [2*NS-1:0]   out_rad,
  output logic [NS+1:0]     out_rem,
  output logic [NS-1:0]     out_root,
  output logic [SIDE_W-1:0] out_side
);
  import qrs_pkg::*;

  logic [NS+1:0]     rem_s, trial, rem_nxt;
  logic [NS-1:0]     root_nxt;
  logic              vld_r;
  logic [2*NS-1:0]   rad_r;
  logic [NS+1:0]     rem_r;
  logic [NS-1:0]     root_r;
  logic [SIDE_W-1:0] side_r;

  // bring in two radicand bits and try the next root bit
  always_comb begin
    rem_s = {in_rem[NS-1:0], in_rad[2*NS-1 -: 2]};
    trial = {in_root, 2'b01};
    if (rem_s >= trial) begin
      rem_nxt  = rem_s - trial;
      root_nxt = {in_root[NS-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_s;
      root_nxt = {in_root[NS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
    rad_r  <= {in_rad[2*NS-3:0], 2'b00};
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    side_r <= in_side;
  end

  assign out_vld  = vld_r;
  assign out_rad  = rad_r;
  assign out_rem  = rem_r;
  assign out_root = root_r;
  assign out_side = side_r;

endmodule

### rtl/qrs_div_cell.sv
// qrs_div_cell: one quotient bit for both root lanes of the divider chain
// depends on qrs_pkg
`timescale 1ns / 1ps

module qrs_div_cell #(
  parameter int NW     = qrs_pkg::COEF_WIDTH_DEF + qrs_pkg::FRAC_BITS_DEF + 2,
  parameter int DNW    = qrs_pkg::COEF_WIDTH_DEF + 1,
  parameter int SIDE_W = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [DNW-1:0]    in_den,
  input  logic [NW-1:0]     in_nq_lo,
  input  logic [NW-1:0]     in_nq_hi,
  input  logic [DNW:0]      in_rem_lo,
  input  logic [DNW:0]      in_rem_hi,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [DNW-1:0]    out_den,
  output logic [NW-1:0]     out_nq_lo,
  output logic [NW-1:0]     out_nq_hi,
  output logic [DNW:0]      out_rem_lo,
  output logic [DNW:0]      out_rem_hi,
  output logic [SIDE_W-1:0] out_side
);
  import qrs_pkg::*;

  logic [DNW:0]      rs_lo, rs_hi, dx;
  logic              qb_lo, qb_hi;
  logic              vld_r;
  logic [DNW-1:0]    den_r;
  logic [NW-1:0]     nq_lo_r, nq_hi_r;
  logic [DNW:0]      rem_lo_r, rem_hi_r;
  logic [SIDE_W-1:0] side_r;

  // restoring step on each lane: shift in a numerator bit, subtract if it fits
  always_comb begin
    dx    = {1'b0, in_den};
    rs_lo = {in_rem_lo[DNW-1:0], in_nq_lo[NW-1]};
    rs_hi = {in_rem_hi[DNW-1:0], in_nq_hi[NW-1]};
    qb_lo = (rs_lo >= dx);
    qb_hi = (rs_hi >= dx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
    den_r    <= in_den;
    nq_lo_r  <= {in_nq_lo[NW-2:0], qb_lo};
    nq_hi_r  <= {in_nq_hi[NW-2:0], qb_hi};
    rem_lo_r <= qb_lo ? rs_lo - dx : rs_lo;
    rem_hi_r <= qb_hi ? rs_hi - dx : rs_hi;
    side_r   <= in_side;
  end

  assign out_vld    = vld_r;
  assign out_den    = den_r;
  assign out_nq_lo  = nq_lo_r;
  assign out_nq_hi  = nq_hi_r;
  assign out_rem_lo = rem_lo_r;
  assign out_rem_hi = rem_hi_r;
  assign out_side   = side_r;

endmodule

### rtl/qrs_checker.sv
// qrs_port_checks: port level checks on the quadratic root solver, bound to the top level
// depends on qrs_pkg and quadratic_root_solver
`timescale 1ns / 1ps

module qrs_port_checks (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [qrs_pkg::CASE_W-1:0]    out_case_code,
  input logic [qrs_pkg::ROOT_W-1:0]    out_root_low,
  input logic [qrs_pkg::ROOT_W-1:0]    out_root_high
);
  import qrs_pkg::*;

  // the block never refuses a beat
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy)
    else $error("busy raised");

  // case code on a result beat is a defined code
  a_case_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_case_code == CASE_ANY || out_case_code == CASE_NONE ||
                   out_case_code == CASE_LINEAR || out_case_code == CASE_TWO ||
                   out_case_code == CASE_NO_REAL))
    else $error("undefined case code");

  // second root only carries data with two real roots
  a_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_case_code != CASE_TWO) |-> out_root_high == '0)
    else $error("second root not cleared");

  // first root is zero unless a root exists
  a_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_case_code != CASE_TWO && out_case_code != CASE_LINEAR)
      |-> out_root_low == '0)
    else $error("first root not cleared");

endmodule

bind quadratic_root_solver qrs_port_checks u_port_checks (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_case_code  (out_case_code),
  .out_root_low   (out_root_low),
  .out_root_high  (out_root_high)
);

### tb/sv/qrs_checker.sv
// qrs_checker: watches the coefficient and root channels of quadratic_root_solver,
// predicts every root beat and compares it with what the block gives; depends on qrs_pkg
`timescale 1ns / 1ps

module qrs_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic signed [15:0]    in_coef_square,
  input  logic signed [15:0]    in_coef_linear,
  input  logic signed [15:0]    in_coef_const,
  input  logic                  out_valid,
  input  logic [qrs_pkg::CASE_W-1:0]        out_case_code,
  input  logic signed [qrs_pkg::ROOT_W-1:0] out_root_low,
  input  logic signed [qrs_pkg::ROOT_W-1:0] out_root_high,
  output int                    fail_count,
  output int                    roots_pending
);
  import qrs_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;

  typedef struct packed {
    case_t                     code;
    logic signed [ROOT_W-1:0]  lo;
    logic signed [ROOT_W-1:0]  hi;
  } roots_t;

  roots_t expected_roots[$];

  // clamp to the 48-bit signed range of the root ports
  function automatic logic signed [ROOT_W-1:0] clamp_root(longint v);
    longint top_v;
    top_v = (longint'(1) <<< (ROOT_W - 1)) - 1;
    if (v > top_v) v = top_v;
    if (v < -top_v - 1) v = -top_v - 1;
    return v[ROOT_W-1:0];
  endfunction

  // floored square root of a 128-bit value, one bit at a time
  function automatic logic [63:0] floor_sqrt(logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  t;
    r = '0;
    for (int k = 62; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if ({64'd0, t} * {64'd0, t} <= v) r = t;
    end
    return r;
  endfunction

  function automatic roots_t solve_quadratic(longint a, longint b, longint c);
    roots_t       r;
    longint       disc;
    logic [127:0] wide;
    longint       s;
    longint       nb;
    r = '{code: CASE_ANY, lo: '0, hi: '0};
    if (a == 0) begin
      if (b == 0) begin
        r.code = (c == 0) ? CASE_ANY : CASE_NONE;
      end else begin
        r.code = CASE_LINEAR;
        r.lo   = clamp_root((-c * (longint'(1) <<< FRAC)) / b);
      end
      return r;
    end
    disc = b * b - 4 * a * c;
    if (disc < 0) begin
      r.code = CASE_NO_REAL;
      return r;
    end
    wide   = 128'(disc) << (2 * FRAC);
    s      = longint'(floor_sqrt(wide));
    nb     = -b * (longint'(1) <<< FRAC);
    r.code = CASE_TWO;
    r.lo   = clamp_root((nb - s) / (2 * a));
    r.hi   = clamp_root((nb + s) / (2 * a));
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count    = 0;
    roots_pending = 0;
  end

  // predict on each accepted coefficient beat, compare on each root beat
  always @(posedge clk) begin
    roots_t want;
    if (rst_n) begin
      if (start && !busy)
        expected_roots.push_back(solve_quadratic(in_coef_square, in_coef_linear,
                                                 in_coef_const));
      if (out_valid) begin
        if (expected_roots.size() == 0) begin
          report_mismatch("unexpected root beat", 1, 0);
        end else begin
          want = expected_roots.pop_front();
          if (out_case_code !== want.code)
            report_mismatch("case_code", out_case_code, want.code);
          if (out_root_low !== want.lo)
            report_mismatch("root_low", out_root_low, want.lo);
          if (out_root_high !== want.hi)
            report_mismatch("root_high", out_root_high, want.hi);
        end
      end
    end
    roots_pending = expected_roots.size();
  end

endmodule

### tb/sv/tb_quadratic_root_solver.sv
// tb_quadratic_root_solver: coefficient stimulus in bursts, directed then random,
// with qrs_checker beside the block for prediction; depends on qrs_pkg, qrs_checker
`timescale 1ns / 1ps

module tb_quadratic_root_solver;
  import qrs_pkg::*;

  localparam int RANDOM_ITEMS = 1330;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 90;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [15:0] in_coef_square;
  logic signed [15:0] in_coef_linear;
  logic signed [15:0] in_coef_const;
  logic out_valid;
  logic [CASE_W-1:0] out_case_code;
  logic signed [ROOT_W-1:0] out_root_low;
  logic signed [ROOT_W-1:0] out_root_high;
  int fail_count;
  int roots_pending;
  int idle_cycles;

  quadratic_root_solver u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_coef_square(in_coef_square), .in_coef_linear(in_coef_linear),
    .in_coef_const(in_coef_const), .out_valid(out_valid),
    .out_case_code(out_case_code), .out_root_low(out_root_low),
    .out_root_high(out_root_high)
  );

  qrs_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_coef_square(in_coef_square), .in_coef_linear(in_coef_linear),
    .in_coef_const(in_coef_const), .out_valid(out_valid),
    .out_case_code(out_case_code), .out_root_low(out_root_low),
    .out_root_high(out_root_high), .fail_count(fail_count),
    .roots_pending(roots_pending)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // watchdog on cycles with no beat in either direction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one coefficient beat, held until busy is low at the edge
  task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    logic taken;
    start          <= 1'b1;
    in_coef_square <= a;
    in_coef_linear <= b;
    in_coef_const  <= c;
    taken = !busy;
    @(posedge clk);
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // a gap of n idle cycles; nothing to do for an empty gap
  task automatic idle_gap(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // mostly small coefficients so that every case turns up often
  function automatic logic [15:0] pick_coef(int kind);
    case (kind)
      0: return 16'd0;
      1: return 16'($signed($urandom_range(0, 20)) - 10);
      2: return 16'($signed($urandom_range(0, 600)) - 300);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] a, b, c;
    int burst;
    rst_n = 1'b0;
    start = 1'b0;
    in_coef_square = '0;
    in_coef_linear = '0;
    in_coef_const  = '0;
    idle_cycles    = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: every case, zero discriminant, negative a, field extremes
    send_coefs(16'd0, 16'd0, 16'd0);
    send_coefs(16'd0, 16'd0, 16'd5);
    send_coefs(16'd0, 16'd3, 16'd0);
    send_coefs(16'd0, 16'd3, -16'sd7);
    send_coefs(16'd0, 16'h8000, 16'h7fff);
    send_coefs(16'd0, 16'h7fff, 16'h8000);
    send_coefs(16'd0, -16'sd1, 16'h8000);
    send_coefs(16'd1, -16'sd3, 16'd2);
    send_coefs(16'd1, 16'd2, 16'd1);
    send_coefs(16'd1, 16'd0, 16'd1);
    send_coefs(-16'sd1, 16'd3, 16'd4);
    send_coefs(-16'sd2, 16'd0, 16'd8);
    send_coefs(16'd3, 16'd5, -16'sd2);
    idle_gap(3);
    send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
    send_coefs(16'h8000, 16'h8000, 16'h8000);
    send_coefs(16'h8000, 16'h7fff, 16'h7fff);
    send_coefs(16'h7fff, 16'h8000, 16'h8000);
    send_coefs(16'd1, 16'h8000, 16'h8000);
    send_coefs(16'h8000, 16'd0, 16'h7fff);
    send_coefs(16'd1, 16'hffff, 16'h7fff);
    send_coefs(16'hffff, 16'hffff, 16'hffff);
    send_coefs(16'h8000, 16'h8000, 16'd0);

    // random bursts with random gaps, some long runs without gaps
    for (int n = 0; n < RANDOM_ITEMS; ) begin
      burst = $urandom_range(1, ($urandom_range(0, 5) == 0) ? 60 : 8);
      for (int k = 0; k < burst && n < RANDOM_ITEMS; k++, n++) begin
        a = pick_coef($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 3));
        b = pick_coef($urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 3));
        c = pick_coef($urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 3));
        // perfect squares now and then for equal roots
        if ($urandom_range(0, 15) == 0) begin
          a = 16'($urandom_range(1, 20));
          b = 16'(2 * a * $signed($urandom_range(0, 20) - 10));
          c = 16'(int'($signed(b) / 2) * int'($signed(b) / 2) / int'($signed(a)));
        end
        send_coefs(a, b, c);
      end
      idle_gap($urandom_range(0, 4) == 0 ? $urandom_range(5, 40) : $urandom_range(0, 3));
    end
    start <= 1'b0;

    // drain the pipeline
    while (roots_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
rtl/qrs_pkg.sv
rtl/qrs_front.sv
rtl/qrs_sqrt_cell.sv
rtl/qrs_div_cell.sv
rtl/quadratic_root_solver.sv
rtl/qrs_checker.sv
tb/sv/qrs_checker.sv
tb/sv/tb_quadratic_root_solver.sv
